// File: rtl/core/dlsr_pkg.sv
package dlsr_pkg;

  // Field widths
  localparam int ACT_W     = 3;
  localparam int KIND_W    = 3;
  localparam int IDX_W     = 7;
  localparam int CRD_W     = 12;
  localparam int ROW_SEL_W = 5;
  localparam int PIX_W     = 64;
  localparam int CNT_W     = 8;
  localparam int STAT_W    = 2;

  // Working coordinate width for spans and row offsets
  localparam int WK_W      = 14;
  // Bresenham error and delta width
  localparam int LN_W      = 15;
  // Disc half-width search
  localparam int SQ_IN_W   = 22;
  localparam int SQ_OUT_W  = 11;

  // Command codes
  localparam logic [ACT_W-1:0] ACT_ADD    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_MODIFY = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd4;

  // Shape kinds
  localparam logic [KIND_W-1:0] KIND_RECT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FILL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LINE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISC    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRI     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_DIAMOND = 3'd5;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] w;
    logic signed [CRD_W-1:0] h;
  } shape_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic set_full;
    logic set_bad;
    logic list_add;
    logic list_rd_idx;
    logic mod_wr;
    logic shift_init;
    logic shift_step;
    logic total_dec;
    logic total_clr;
    logic fb_rd_sel;
    logic clear_step;
    logic shape_rd;
    logic shape_load;
    logic next_shape;
    logic row_setup;
    logic row_disc;
    logic row_wr;
    logic line_rd;
    logic line_wr;
    logic line_step;
    logic pix_cap;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic list_full;
    logic idx_bad;
    logic shift_none;
    logic shift_last;
    logic row_ok;
    logic shapes_done;
    logic kind_line;
    logic kind_rows;
    logic row_sqrt;
    logic row_last;
    logic sqrt_done;
    logic line_on;
    logic line_end;
    logic out_free;
  } stat_t;

endpackage

// File: rtl/core/dlsr_ram.sv
module dlsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/dlsr_sqrt.sv
module dlsr_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [dlsr_pkg::SQ_IN_W-1:0]  radicand_i,
  output logic                          done_o,
  output logic [dlsr_pkg::SQ_OUT_W-1:0] root_o
);

  localparam int OW = dlsr_pkg::SQ_OUT_W;
  localparam int IW = dlsr_pkg::SQ_IN_W;

  logic          busy_q;
  logic [IW-1:0] rad_q;
  logic [OW-1:0] root_q;
  logic [OW-1:0] bit_q;
  logic [OW-1:0] cand;
  logic [IW-1:0] cand_sq;

  // Try one result bit per cycle, most significant first
  assign cand    = root_q | bit_q;
  assign cand_sq = {{(IW-OW){1'b0}}, cand} * {{(IW-OW){1'b0}}, cand};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      bit_q  <= {1'b1, {(OW-1){1'b0}}};
    end else if (busy_q) begin
      if (cand_sq <= rad_q) begin
        root_q <= cand;
      end
      bit_q <= bit_q >> 1;
    end
  end

  assign done_o = !busy_q;
  assign root_o = root_q;

endmodule

// File: rtl/core/dlsr_ctrl.sv
module dlsr_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  dlsr_pkg::stat_t stat_i,
  output dlsr_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_MOD_WR    = 4'd2;
  localparam logic [3:0] S_SHIFT     = 4'd3;
  localparam logic [3:0] S_CLEAR     = 4'd4;
  localparam logic [3:0] S_NEXT      = 4'd5;
  localparam logic [3:0] S_LOAD      = 4'd6;
  localparam logic [3:0] S_GO        = 4'd7;
  localparam logic [3:0] S_ROW_START = 4'd8;
  localparam logic [3:0] S_ROW_SQRT  = 4'd9;
  localparam logic [3:0] S_ROW_WR    = 4'd10;
  localparam logic [3:0] S_LINE_PLOT = 4'd11;
  localparam logic [3:0] S_LINE_WR   = 4'd12;
  localparam logic [3:0] S_READ      = 4'd13;
  localparam logic [3:0] S_RESP      = 4'd14;

  logic [3:0] state_q;
  logic [3:0] state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Sequence one command through list update and redraw, or row read, then response
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_RESP;
        case (stat_i.action)
          dlsr_pkg::ACT_ADD: begin
            if (stat_i.list_full) begin
              cmd_o.set_full = 1'b1;
            end else begin
              cmd_o.list_add = 1'b1;
              state_d        = S_CLEAR;
            end
          end
          dlsr_pkg::ACT_MODIFY: begin
            if (stat_i.idx_bad) begin
              cmd_o.set_bad = 1'b1;
            end else begin
              cmd_o.list_rd_idx = 1'b1;
              state_d           = S_MOD_WR;
            end
          end
          dlsr_pkg::ACT_DELETE: begin
            if (stat_i.idx_bad) begin
              cmd_o.set_bad = 1'b1;
            end else if (stat_i.shift_none) begin
              cmd_o.total_dec = 1'b1;
              state_d         = S_CLEAR;
            end else begin
              cmd_o.shift_init = 1'b1;
              state_d          = S_SHIFT;
            end
          end
          dlsr_pkg::ACT_CLEAR: begin
            cmd_o.total_clr = 1'b1;
            state_d         = S_CLEAR;
          end
          dlsr_pkg::ACT_READ: begin
            if (stat_i.row_ok) begin
              cmd_o.fb_rd_sel = 1'b1;
              state_d         = S_READ;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_MOD_WR: begin
        cmd_o.mod_wr = 1'b1;
        state_d      = S_CLEAR;
      end
      S_SHIFT: begin
        cmd_o.shift_step = 1'b1;
        if (stat_i.shift_last) begin
          cmd_o.total_dec = 1'b1;
          state_d         = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.row_last) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (stat_i.shapes_done) begin
          state_d = S_RESP;
        end else begin
          cmd_o.shape_rd = 1'b1;
          state_d        = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.shape_load = 1'b1;
        state_d          = S_GO;
      end
      S_GO: begin
        if (stat_i.kind_line) begin
          state_d = S_LINE_PLOT;
        end else if (stat_i.kind_rows) begin
          state_d = S_ROW_START;
        end else begin
          cmd_o.next_shape = 1'b1;
          state_d          = S_NEXT;
        end
      end
      S_ROW_START: begin
        cmd_o.row_setup = 1'b1;
        state_d         = stat_i.row_sqrt ? S_ROW_SQRT : S_ROW_WR;
      end
      S_ROW_SQRT: begin
        if (stat_i.sqrt_done) begin
          cmd_o.row_disc = 1'b1;
          state_d        = S_ROW_WR;
        end
      end
      S_ROW_WR: begin
        cmd_o.row_wr = 1'b1;
        if (stat_i.row_last) begin
          cmd_o.next_shape = 1'b1;
          state_d          = S_NEXT;
        end else begin
          state_d = S_ROW_START;
        end
      end
      S_LINE_PLOT: begin
        if (stat_i.line_on) begin
          cmd_o.line_rd = 1'b1;
          state_d       = S_LINE_WR;
        end else if (stat_i.line_end) begin
          cmd_o.next_shape = 1'b1;
          state_d          = S_NEXT;
        end else begin
          cmd_o.line_step = 1'b1;
        end
      end
      S_LINE_WR: begin
        cmd_o.line_wr = 1'b1;
        if (stat_i.line_end) begin
          cmd_o.next_shape = 1'b1;
          state_d          = S_NEXT;
        end else begin
          cmd_o.line_step = 1'b1;
          state_d         = S_LINE_PLOT;
        end
      end
      S_READ: begin
        cmd_o.pix_cap = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/dlsr_datapath.sv
module dlsr_datapath #(
  parameter int CANVAS_W   = 64,
  parameter int CANVAS_H   = 32,
  parameter int LIST_DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dlsr_pkg::cmd_t                         cmd_i,
  output dlsr_pkg::stat_t                        stat_o,
  input  logic [dlsr_pkg::ACT_W-1:0]             action_i,
  input  logic [dlsr_pkg::KIND_W-1:0]            shape_kind_i,
  input  logic [dlsr_pkg::IDX_W-1:0]             entry_index_i,
  input  logic signed [dlsr_pkg::CRD_W-1:0]      pos_x_i,
  input  logic signed [dlsr_pkg::CRD_W-1:0]      pos_y_i,
  input  logic signed [dlsr_pkg::CRD_W-1:0]      size_w_i,
  input  logic signed [dlsr_pkg::CRD_W-1:0]      size_h_i,
  input  logic [dlsr_pkg::ROW_SEL_W-1:0]         row_select_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic [dlsr_pkg::PIX_W-1:0]             row_pixels_o,
  output logic [dlsr_pkg::CNT_W-1:0]             list_count_o,
  output logic [dlsr_pkg::STAT_W-1:0]            status_o
);

  localparam int AW  = (CANVAS_H > 1) ? $clog2(CANVAS_H) : 1;
  localparam int LAW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int TW  = $clog2(LIST_DEPTH + 1);
  localparam int XW  = ((TW > dlsr_pkg::IDX_W) ? TW : dlsr_pkg::IDX_W) + 1;
  localparam int WK  = dlsr_pkg::WK_W;
  localparam int LN  = dlsr_pkg::LN_W;
  localparam int CW  = dlsr_pkg::CRD_W;
  localparam int OW  = dlsr_pkg::SQ_OUT_W;
  localparam int IW  = dlsr_pkg::SQ_IN_W;
  localparam int SW  = $bits(dlsr_pkg::shape_t);
  localparam logic signed [WK-1:0] W_S = WK'(CANVAS_W);
  localparam logic signed [WK-1:0] H_S = WK'(CANVAS_H);

  // Latched command
  logic [dlsr_pkg::ACT_W-1:0]     act_q;
  logic [dlsr_pkg::IDX_W-1:0]     idx_q;
  logic [dlsr_pkg::ROW_SEL_W-1:0] row_sel_q;
  dlsr_pkg::shape_t               new_q;

  // Control counters
  logic [TW-1:0] total_q;
  logic [TW-1:0] k_q;
  logic [AW-1:0] r_q;
  logic [AW-1:0] r_next;
  logic [CANVAS_H-1:0] fb_valid_q;
  logic          rd_valid_q;

  // Current shape and row descriptor
  dlsr_pkg::shape_t        sh_q;
  logic                    span_en_q;
  logic                    pt_en_q;
  logic signed [WK-1:0]    sa_q;
  logic signed [WK-1:0]    sb_q;
  logic signed [WK-1:0]    p1_q;
  logic signed [WK-1:0]    p2_q;

  // Line walker
  logic signed [CW-1:0] lx_q;
  logic signed [CW-1:0] ly_q;
  logic signed [LN-1:0] ldx_q;
  logic signed [LN-1:0] ldy_q;
  logic signed [LN-1:0] lerr_q;
  logic                 lsx_q;
  logic                 lsy_q;

  // Result
  logic [dlsr_pkg::STAT_W-1:0] status_q;
  logic [CANVAS_W-1:0]         pix_q;
  logic                        out_valid_q;
  logic [dlsr_pkg::PIX_W-1:0]  out_pix_q;
  logic [dlsr_pkg::CNT_W-1:0]  out_cnt_q;
  logic [dlsr_pkg::STAT_W-1:0] out_st_q;

  // Memory ports
  logic               l_we;
  logic [LAW-1:0]     l_waddr;
  dlsr_pkg::shape_t   l_wdata;
  logic               l_re;
  logic [LAW-1:0]     l_raddr;
  logic [SW-1:0]      l_rdata;
  dlsr_pkg::shape_t   lr;
  logic               f_we;
  logic [AW-1:0]      f_waddr;
  logic [CANVAS_W-1:0] f_wdata;
  logic               f_re;
  logic [AW-1:0]      f_raddr;
  logic [CANVAS_W-1:0] f_rdata_raw;
  logic [CANVAS_W-1:0] f_rdata;

  logic [XW-1:0] idx_x;
  logic [XW-1:0] k_x;
  logic [XW-1:0] tot_x;

  // Row geometry
  logic signed [WK-1:0] xs, ys, ws, hs, rs, x2, y2, dy, ady, half;
  logic                 span_en_d, pt_en_d, need_sqrt;
  logic signed [WK-1:0] sa_d, sb_d;
  logic [OW-1:0]        w11, a11, root, hw;
  logic [IW-1:0]        rad;
  logic                 sqrt_done;
  logic [CANVAS_W-1:0]  mrow, mline;

  // Line step
  logic signed [LN:0]   e2;
  logic                 c1, c2;
  logic signed [LN-1:0] lerr_d;
  logic signed [LN-1:0] ix_diff, iy_diff, ix_abs, iy_abs;
  logic signed [WK-1:0] lxw, lyw;

  assign idx_x = XW'(idx_q);
  assign k_x   = XW'(k_q);
  assign tot_x = XW'(total_q);
  assign lr    = dlsr_pkg::shape_t'(l_rdata);
  assign r_next = (r_q == AW'(CANVAS_H - 1)) ? '0 : r_q + AW'(1);

  // Shape list port selection
  always_comb begin
    l_we    = cmd_i.list_add | cmd_i.mod_wr | cmd_i.shift_step;
    l_waddr = LAW'(k_q);
    l_wdata = lr;
    if (cmd_i.list_add) begin
      l_waddr = LAW'(total_q);
      l_wdata = new_q;
    end else if (cmd_i.mod_wr) begin
      l_waddr      = LAW'(idx_q);
      l_wdata      = new_q;
      l_wdata.kind = lr.kind;
    end
    l_re    = cmd_i.list_rd_idx | cmd_i.shift_init | cmd_i.shift_step | cmd_i.shape_rd;
    l_raddr = LAW'(k_q);
    if (cmd_i.list_rd_idx) begin
      l_raddr = LAW'(idx_q);
    end else if (cmd_i.shift_init) begin
      l_raddr = LAW'(idx_x + XW'(1));
    end else if (cmd_i.shift_step) begin
      l_raddr = LAW'(k_x + XW'(2));
    end
  end

  dlsr_ram #(
    .WIDTH (SW),
    .DEPTH (LIST_DEPTH)
  ) u_list (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  // Framebuffer port selection
  always_comb begin
    f_re    = cmd_i.fb_rd_sel | cmd_i.line_rd | cmd_i.row_setup;
    f_raddr = r_q;
    if (cmd_i.fb_rd_sel) begin
      f_raddr = AW'(row_sel_q);
    end else if (cmd_i.line_rd) begin
      f_raddr = AW'(ly_q);
    end
    f_we    = cmd_i.clear_step | cmd_i.row_wr | cmd_i.line_wr;
    f_waddr = cmd_i.line_wr ? AW'(ly_q) : r_q;
    f_wdata = '0;
    if (cmd_i.row_wr) begin
      f_wdata = f_rdata | mrow;
    end else if (cmd_i.line_wr) begin
      f_wdata = f_rdata | mline;
    end
  end

  dlsr_ram #(
    .WIDTH (CANVAS_W),
    .DEPTH (CANVAS_H)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (f_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata_raw)
  );

  // Rows never written since reset read as background
  assign f_rdata = rd_valid_q ? f_rdata_raw : '0;

  // Per-row span of the current shape
  always_comb begin
    xs   = WK'(sh_q.x);
    ys   = WK'(sh_q.y);
    ws   = WK'(sh_q.w);
    hs   = WK'(sh_q.h);
    rs   = $signed(WK'(r_q));
    x2   = xs + ws - WK'(1);
    y2   = ys + hs - WK'(1);
    dy   = rs - ys;
    ady  = (dy < 0) ? -dy : dy;
    half = ws - ady;
    span_en_d = 1'b0;
    pt_en_d   = 1'b0;
    need_sqrt = 1'b0;
    sa_d      = xs;
    sb_d      = x2;
    case (sh_q.kind)
      dlsr_pkg::KIND_RECT: begin
        span_en_d = (ws > 0) && ((rs == ys) || (rs == y2));
        pt_en_d   = (hs > 0) && (rs >= ys) && (rs <= y2);
      end
      dlsr_pkg::KIND_FILL: begin
        span_en_d = (rs >= ys) && (rs <= y2);
      end
      dlsr_pkg::KIND_TRI: begin
        span_en_d = (dy >= 0) && (dy < ws);
        sb_d      = xs + dy;
      end
      dlsr_pkg::KIND_DIAMOND: begin
        span_en_d = (ws >= 0) && (ady <= ws);
        sa_d      = xs - half;
        sb_d      = xs + half;
      end
      dlsr_pkg::KIND_DISC: begin
        need_sqrt = (ws >= 0) && (ady <= ws);
      end
      default: begin
        span_en_d = 1'b0;
      end
    endcase
  end

  // Disc: largest dx with dx*dx <= r*r + 1 - dy*dy
  assign w11 = OW'(sh_q.w);
  assign a11 = OW'(ady);
  assign rad = {{(IW-OW){1'b0}}, w11} * {{(IW-OW){1'b0}}, w11} + IW'(1)
             - {{(IW-OW){1'b0}}, a11} * {{(IW-OW){1'b0}}, a11};
  assign hw  = (root < w11) ? root : w11;

  dlsr_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.row_setup & need_sqrt),
    .radicand_i (rad),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Pixel masks for one row
  always_comb begin
    for (int j = 0; j < CANVAS_W; j++) begin
      mrow[j]  = (span_en_q && ($signed(WK'(j)) >= sa_q) && ($signed(WK'(j)) <= sb_q)) ||
                 (pt_en_q && (($signed(WK'(j)) == p1_q) || ($signed(WK'(j)) == p2_q)));
      mline[j] = ($signed(CW'(j)) == lx_q);
    end
  end

  // Bresenham step and start values
  always_comb begin
    e2     = {lerr_q, 1'b0};
    c1     = e2 > -(LN+1)'(ldy_q);
    c2     = e2 < (LN+1)'(ldx_q);
    lerr_d = lerr_q;
    if (c1) begin
      lerr_d = lerr_d - ldy_q;
    end
    if (c2) begin
      lerr_d = lerr_d + ldx_q;
    end
    ix_diff = LN'(lr.w) - LN'(lr.x);
    iy_diff = LN'(lr.h) - LN'(lr.y);
    ix_abs  = (ix_diff < 0) ? -ix_diff : ix_diff;
    iy_abs  = (iy_diff < 0) ? -iy_diff : iy_diff;
    lxw     = WK'(lx_q);
    lyw     = WK'(ly_q);
  end

  // Status toward the controller
  always_comb begin
    stat_o             = '0;
    stat_o.action      = act_q;
    stat_o.list_full   = tot_x >= XW'(LIST_DEPTH);
    stat_o.idx_bad     = idx_x >= tot_x;
    stat_o.shift_none  = (idx_x + XW'(1)) == tot_x;
    stat_o.shift_last  = (k_x + XW'(2)) == tot_x;
    stat_o.row_ok      = int'(row_sel_q) < CANVAS_H;
    stat_o.shapes_done = k_q == total_q;
    stat_o.kind_line   = sh_q.kind == dlsr_pkg::KIND_LINE;
    stat_o.kind_rows   = sh_q.kind inside {dlsr_pkg::KIND_RECT, dlsr_pkg::KIND_FILL,
                                           dlsr_pkg::KIND_DISC, dlsr_pkg::KIND_TRI,
                                           dlsr_pkg::KIND_DIAMOND};
    stat_o.row_sqrt    = need_sqrt;
    stat_o.row_last    = r_q == AW'(CANVAS_H - 1);
    stat_o.sqrt_done   = sqrt_done;
    stat_o.line_on     = (lxw >= 0) && (lxw < W_S) && (lyw >= 0) && (lyw < H_S);
    stat_o.line_end    = (lx_q == sh_q.w) && (ly_q == sh_q.h);
    stat_o.out_free    = !out_valid_q || out_ready_i;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      k_q         <= '0;
      r_q         <= '0;
      fb_valid_q  <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.list_add) begin
        total_q <= total_q + TW'(1);
      end else if (cmd_i.total_dec) begin
        total_q <= total_q - TW'(1);
      end else if (cmd_i.total_clr) begin
        total_q <= '0;
      end
      if (cmd_i.shift_init) begin
        k_q <= TW'(idx_q);
      end else if (cmd_i.clear_step) begin
        k_q <= '0;
      end else if (cmd_i.shift_step || cmd_i.next_shape) begin
        k_q <= k_q + TW'(1);
      end
      if (cmd_i.latch || cmd_i.shape_load) begin
        r_q <= '0;
      end else if (cmd_i.clear_step || cmd_i.row_wr) begin
        r_q <= r_next;
      end
      if (f_we) begin
        fb_valid_q[f_waddr] <= 1'b1;
      end
      if (f_re) begin
        rd_valid_q <= fb_valid_q[f_raddr];
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q      <= action_i;
      idx_q      <= entry_index_i;
      row_sel_q  <= row_select_i;
      new_q.kind <= shape_kind_i;
      new_q.x    <= pos_x_i;
      new_q.y    <= pos_y_i;
      new_q.w    <= size_w_i;
      new_q.h    <= size_h_i;
      status_q   <= dlsr_pkg::ST_OK;
      pix_q      <= '0;
    end
    if (cmd_i.set_full) begin
      status_q <= dlsr_pkg::ST_FULL;
    end
    if (cmd_i.set_bad) begin
      status_q <= dlsr_pkg::ST_BAD;
    end
    if (cmd_i.pix_cap) begin
      pix_q <= f_rdata;
    end
    if (cmd_i.shape_load) begin
      sh_q   <= lr;
      lx_q   <= lr.x;
      ly_q   <= lr.y;
      ldx_q  <= ix_abs;
      ldy_q  <= iy_abs;
      lerr_q <= ix_abs - iy_abs;
      lsx_q  <= lr.x < lr.w;
      lsy_q  <= lr.y < lr.h;
    end
    if (cmd_i.line_step) begin
      lerr_q <= lerr_d;
      if (c1) begin
        lx_q <= lsx_q ? lx_q + CW'(1) : lx_q - CW'(1);
      end
      if (c2) begin
        ly_q <= lsy_q ? ly_q + CW'(1) : ly_q - CW'(1);
      end
    end
    if (cmd_i.row_setup) begin
      span_en_q <= span_en_d;
      pt_en_q   <= pt_en_d;
      sa_q      <= sa_d;
      sb_q      <= sb_d;
      p1_q      <= xs;
      p2_q      <= x2;
    end
    if (cmd_i.row_disc) begin
      span_en_q <= 1'b1;
      sa_q      <= xs - $signed(WK'(hw));
      sb_q      <= xs + $signed(WK'(hw));
    end
    if (cmd_i.out_load) begin
      out_pix_q <= dlsr_pkg::PIX_W'(pix_q);
      out_cnt_q <= dlsr_pkg::CNT_W'(total_q);
      out_st_q  <= status_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_pixels_o = out_pix_q;
  assign list_count_o = out_cnt_q;
  assign status_o     = out_st_q;

endmodule

// File: rtl/core/display_list_shape_rasterizer.sv
// Read row: the selected framebuffer row is returned. Rejected commands respond without a redraw.
// List change: the framebuffer is cleared, then each shape is drawn row by row
// (discs run the 11-step half-width search on each row they cover), or by
// Bresenham steps for lines; one command is handled at a time.
// Reset clears the list count and marks every framebuffer row as background.
module display_list_shape_rasterizer #(
  parameter int CANVAS_W   = 64,
  parameter int CANVAS_H   = 32,
  parameter int LIST_DEPTH = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dlsr_pkg::ACT_W-1:0]          action_i,
  input  logic [dlsr_pkg::KIND_W-1:0]         shape_kind_i,
  input  logic [dlsr_pkg::IDX_W-1:0]          entry_index_i,
  input  logic signed [dlsr_pkg::CRD_W-1:0]   pos_x_i,
  input  logic signed [dlsr_pkg::CRD_W-1:0]   pos_y_i,
  input  logic signed [dlsr_pkg::CRD_W-1:0]   size_w_i,
  input  logic signed [dlsr_pkg::CRD_W-1:0]   size_h_i,
  input  logic [dlsr_pkg::ROW_SEL_W-1:0]      row_select_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dlsr_pkg::PIX_W-1:0]          row_pixels_o,
  output logic [dlsr_pkg::CNT_W-1:0]          list_count_o,
  output logic [dlsr_pkg::STAT_W-1:0]         status_o
);

  dlsr_pkg::cmd_t  cmd;
  dlsr_pkg::stat_t stat;

  // Sequence commands
  dlsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Hold list, framebuffer and drawing units
  dlsr_datapath #(
    .CANVAS_W   (CANVAS_W),
    .CANVAS_H   (CANVAS_H),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .action_i      (action_i),
    .shape_kind_i  (shape_kind_i),
    .entry_index_i (entry_index_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .size_w_i      (size_w_i),
    .size_h_i      (size_h_i),
    .row_select_i  (row_select_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .row_pixels_o  (row_pixels_o),
    .list_count_o  (list_count_o),
    .status_o      (status_o)
  );

endmodule
